>>> src/tlpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_pkg
// Shared constants and types for the thermal line packet deframer.
// ----------------------------------------------------------------------------
package tlpd_pkg;

	localparam int PACKET_BYTES    = 164;
	localparam int LINES_PER_FRAME = 60;
	localparam int PIXELS_PER_LINE = 80;
	localparam int PAYLOAD_START   = 4;
	localparam int PAYLOAD_END     = PAYLOAD_START + 2 * PIXELS_PER_LINE;

	localparam logic [3:0] DISCARD_NIBBLE = 4'hF;

	localparam logic [7:0] LAST_POS    = 8'(PACKET_BYTES - 1);
	localparam logic [7:0] ID_POS      = 8'd0;
	localparam logic [7:0] NUMBER_POS  = 8'd1;
	localparam logic [7:0] PAY_START_B = 8'(PAYLOAD_START);
	localparam logic [8:0] PAY_END_B   = 9'(PAYLOAD_END);
	localparam logic [7:0] LINES_B     = 8'(LINES_PER_FRAME);
	localparam logic [7:0] DONE_LINE_B = 8'(LINES_PER_FRAME - 1);

	typedef struct packed {
		logic        pixel_valid;
		logic [5:0]  row;
		logic [6:0]  column;
		logic [15:0] pixel;
		logic        frame_done;
	} result_t;

endpackage

>>> src/tlpd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_in_reg
// Input word register; holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module tlpd_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] rx_byte,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  logic       advance,
	output logic [7:0] byte_s1,
	output logic       fire
);

	logic valid_s1;

	assign fire       = valid_s1 & advance;
	assign byte_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

>>> src/tlpd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_parser
// Packet position tracking, header capture and pixel assembly.
// ----------------------------------------------------------------------------
module tlpd_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        byte_s1,
	output tlpd_pkg::result_t res,
	output logic              res_hit
);

	logic [7:0] pos_q;
	logic       discard_q;
	logic [7:0] pkt_num_q;
	logic [7:0] high_q;

	logic [7:0] off;
	logic       in_payload;
	logic       pix;
	logic       done;

	assign off        = pos_q - tlpd_pkg::PAY_START_B;
	assign in_payload = (pos_q >= tlpd_pkg::PAY_START_B) &&
	                    ({1'b0, pos_q} < tlpd_pkg::PAY_END_B);

	always_comb begin
		pix  = in_payload && off[0] && !discard_q && (pkt_num_q < tlpd_pkg::LINES_B);
		done = (pos_q == tlpd_pkg::LAST_POS) && !discard_q &&
		       (pkt_num_q >= tlpd_pkg::DONE_LINE_B);
		res.pixel_valid = pix;
		res.row         = pix ? pkt_num_q[5:0] : 6'd0;
		res.column      = pix ? off[7:1] : 7'd0;
		res.pixel       = pix ? {high_q, byte_s1} : 16'd0;
		res.frame_done  = done;
		res_hit         = pix | done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= 8'd0;
			discard_q <= 1'b0;
			pkt_num_q <= 8'd0;
			high_q    <= 8'd0;
		end else if (fire) begin
			pos_q <= (pos_q >= tlpd_pkg::LAST_POS) ? 8'd0 : pos_q + 8'd1;
			if (pos_q == tlpd_pkg::ID_POS) begin
				discard_q <= (byte_s1[3:0] == tlpd_pkg::DISCARD_NIBBLE);
			end
			if (pos_q == tlpd_pkg::NUMBER_POS) begin
				pkt_num_q <= byte_s1;
			end
			// even payload offset: first byte of a pixel pair
			if (in_payload && !off[0]) begin
				high_q <= byte_s1;
			end
		end
	end

endmodule

>>> src/tlpd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_out_reg
// Result register; loads whenever empty or the word is being taken.
// ----------------------------------------------------------------------------
module tlpd_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  tlpd_pkg::result_t res,
	input  logic              res_hit,
	output logic              advance,
	output logic              result_valid,
	input  logic              result_stall,
	output tlpd_pkg::result_t res_s2
);

	logic valid_s2;

	assign advance      = ~valid_s2 | ~result_stall;
	assign result_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= fire & res_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire && res_hit) begin
			res_s2 <= res;
		end
	end

endmodule

>>> src/thermal_line_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_line_packet_deframer
// A byte is held in the input register, and its result word in the result register.
// Throughput: one byte per cycle while result_stall is low; a waiting result
// stalls the input side once the input register holds a byte.
// Reset (arst_n low): packet position, header state and the valid flags of
// both registers clear; after reset the stream is taken as packet-aligned.
// ----------------------------------------------------------------------------
module thermal_line_packet_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  rx_byte,
	input  logic        byte_valid,
	output logic        byte_stall,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        pixel_valid,
	output logic [5:0]  row,
	output logic [6:0]  column,
	output logic [15:0] pixel,
	output logic        frame_done
);

	logic              advance;
	logic              fire;
	logic [7:0]        byte_s1;
	tlpd_pkg::result_t res;
	logic              res_hit;
	tlpd_pkg::result_t res_s2;

	tlpd_in_reg u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_byte    (rx_byte),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.advance    (advance),
		.byte_s1    (byte_s1),
		.fire       (fire)
	);

	tlpd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.byte_s1 (byte_s1),
		.res     (res),
		.res_hit (res_hit)
	);

	tlpd_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.res          (res),
		.res_hit      (res_hit),
		.advance      (advance),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.res_s2       (res_s2)
	);

	assign pixel_valid = res_s2.pixel_valid;
	assign row         = res_s2.row;
	assign column      = res_s2.column;
	assign pixel       = res_s2.pixel;
	assign frame_done  = res_s2.frame_done;

endmodule

>>> src/tlpd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlpd_checker
// Port-level checks on the deframer's result channel.
// ----------------------------------------------------------------------------
module tlpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic        pixel_valid,
	input logic [5:0]  row,
	input logic [6:0]  column,
	input logic [15:0] pixel,
	input logic        frame_done
);

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(pixel) &&
		$stable(row) && $stable(column) && $stable(frame_done) && $stable(pixel_valid))
		else $error("result word changed while stalled");

	// every word carries a pixel or a frame end
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pixel_valid || frame_done)
		else $error("empty result word");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && pixel_valid |->
		(column < tlpd_pkg::PIXELS_PER_LINE) && (row < tlpd_pkg::LINES_PER_FRAME))
		else $error("pixel row or column out of range");

	// frame end alone: pixel fields are zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pixel_valid |-> row == 6'd0 && column == 7'd0 && pixel == 16'd0)
		else $error("pixel fields not zero without pixel");

endmodule

bind thermal_line_packet_deframer tlpd_checker u_tlpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.pixel_valid  (pixel_valid),
	.row          (row),
	.column       (column),
	.pixel        (pixel),
	.frame_done   (frame_done)
);
